// File: hw/rtl/gmi_pkg.sv
// Shared constants, codes and types for the grid multilinear interpolation core.
package gmi_pkg;

    localparam int AXIS_LEN   = 16;
    localparam int NUM_AXES   = 3;
    localparam int PT_W       = 4;
    localparam int LEN_W      = 5;
    localparam int VAL_W      = 32;
    localparam int FRAC_W     = 17;
    localparam int ADDR_W     = 12;
    localparam int DATA_DEPTH = 4096;
    localparam int ACC_W      = 52;
    localparam int PROD_W     = 50;

    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] OP_LOAD_AXIS = 2'd0;
    localparam logic [1:0] OP_LOAD_DATA = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic [1:0] CFG_NUM_DIMS = 2'd0;
    localparam logic [1:0] CFG_LEN_X    = 2'd1;
    localparam logic [1:0] CFG_LEN_Y    = 2'd2;
    localparam logic [1:0] CFG_LEN_Z    = 2'd3;

    typedef struct packed {
        logic [PT_W-1:0]   lo_pt;
        logic [PT_W-1:0]   hi_pt;
        logic [FRAC_W-1:0] frac;
    } lane_res_t;

endpackage

// File: hw/rtl/gmi_lane.sv
// One axis lane: coordinate table, binary search and serial fraction divider.
module gmi_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [gmi_pkg::PT_W-1:0]          wr_idx,
    input  logic signed [gmi_pkg::VAL_W-1:0]  wr_data,
    input  logic                              start,
    input  logic signed [gmi_pkg::VAL_W-1:0]  key,
    input  logic [gmi_pkg::LEN_W-1:0]         len,
    output logic                              done,
    output gmi_pkg::lane_res_t                res
);
    import gmi_pkg::*;

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_SRCH = 6'b000010,
        L_RDL  = 6'b000100,
        L_RDR  = 6'b001000,
        L_DIV  = 6'b010000,
        L_DONE = 6'b100000
    } lane_state_t;

    lane_state_t state_reg, state_next;
    logic [LEN_W-1:0] lo_reg, lo_next, hi_reg, hi_next, len_reg, len_next;
    logic signed [VAL_W-1:0] key_reg, key_next, pl_reg, pl_next;
    logic [VAL_W:0] den_reg, den_next, rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [PT_W-1:0] lpt_reg, lpt_next, rpt_reg, rpt_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;

    logic signed [VAL_W-1:0] tab [AXIS_LEN];
    logic [PT_W-1:0] rd_addr, mid;
    logic [LEN_W:0] mid_sum;
    logic signed [VAL_W-1:0] rd_data;
    logic signed [VAL_W:0] diff_den, diff_num;
    logic [VAL_W+1:0] rem2;
    logic [LEN_W-1:0] lo_m1, len_m1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tab[wr_idx] <= wr_data;
        end
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[PT_W:1];

    always_comb
    begin
        case (state_reg)
            L_SRCH:  rd_addr = mid;
            L_RDL:   rd_addr = lpt_reg;
            default: rd_addr = rpt_reg;
        endcase
    end

    assign rd_data  = tab[rd_addr];
    assign diff_den = {rd_data[VAL_W-1], rd_data} - {pl_reg[VAL_W-1], pl_reg};
    assign diff_num = {key_reg[VAL_W-1], key_reg} - {pl_reg[VAL_W-1], pl_reg};
    assign rem2     = {rem_reg, 1'b0};
    assign lo_m1    = lo_reg - 1'b1;
    assign len_m1   = len_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        len_next   = len_reg;
        key_next   = key_reg;
        pl_next    = pl_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        lpt_next   = lpt_reg;
        rpt_next   = rpt_reg;
        frac_next  = frac_reg;
        case (state_reg)
            L_IDLE, L_DONE:
            begin
                if (start)
                begin
                    lo_next    = '0;
                    hi_next    = len;
                    len_next   = len;
                    key_next   = key;
                    state_next = L_SRCH;
                end
            end
            L_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    if (key_reg < rd_data)
                    begin
                        hi_next = {1'b0, mid};
                    end
                    else
                    begin
                        lo_next = {1'b0, mid} + 1'b1;
                    end
                end
                else
                begin
                    lpt_next   = (lo_reg == '0) ? '0 : lo_m1[PT_W-1:0];
                    rpt_next   = (lo_reg == len_reg) ? len_m1[PT_W-1:0] : lo_reg[PT_W-1:0];
                    state_next = L_RDL;
                end
            end
            L_RDL:
            begin
                pl_next    = rd_data;
                state_next = L_RDR;
            end
            L_RDR:
            begin
                frac_next  = '0;
                state_next = L_DONE;
                // A flat or descending bracket and a key below it both give fraction zero.
                if (lpt_reg != rpt_reg && !diff_den[VAL_W] && diff_den != '0
                    && !diff_num[VAL_W])
                begin
                    if (diff_num >= diff_den)
                    begin
                        frac_next = ONE_Q16;
                    end
                    else
                    begin
                        den_next   = diff_den;
                        rem_next   = diff_num;
                        q_next     = '0;
                        cnt_next   = '0;
                        state_next = L_DIV;
                    end
                end
            end
            L_DIV:
            begin
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_next = (VAL_W+1)'(rem2 - {1'b0, den_reg});
                    q_next   = {q_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[VAL_W:0];
                    q_next   = {q_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    frac_next  = {1'b0, q_next};
                    state_next = L_DONE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        len_reg  <= len_next;
        key_reg  <= key_next;
        pl_reg   <= pl_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        lpt_reg  <= lpt_next;
        rpt_reg  <= rpt_next;
        frac_reg <= frac_next;
    end

    assign done      = (state_reg == L_DONE);
    assign res.lo_pt = lpt_reg;
    assign res.hi_pt = rpt_reg;
    assign res.frac  = frac_reg;

endmodule

// File: hw/rtl/grid_multilinear_interp_core.sv
// Top level: configuration, axis lanes, data store and corner accumulation.
// A query passes through the axis lanes (up to five search steps, an exit check, two table
// reads, a 16-step divider if needed, the done check), then T_ADDR, T_WGT per axis, T_PROD
// and T_ACC per corner for 2^num_dims corners, then a one-cycle done. Loads give no result.
// Reset clears control state and sets num_dims to 1 and all axis lengths to 16.
// Axis tables and data store are not cleared; the receiver cannot stall the result.
module grid_multilinear_interp_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [gmi_pkg::LEN_W-1:0]         cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic [1:0]                        axis,
    input  logic [gmi_pkg::ADDR_W-1:0]        index,
    input  logic signed [gmi_pkg::VAL_W-1:0]  value,
    input  logic signed [gmi_pkg::VAL_W-1:0]  coord_x,
    input  logic signed [gmi_pkg::VAL_W-1:0]  coord_y,
    input  logic signed [gmi_pkg::VAL_W-1:0]  coord_z,
    output logic                              done,
    output logic signed [gmi_pkg::VAL_W-1:0]  interp_value
);
    import gmi_pkg::*;

    typedef enum logic [6:0] {
        T_IDLE = 7'b0000001,
        T_SRCH = 7'b0000010,
        T_ADDR = 7'b0000100,
        T_WGT  = 7'b0001000,
        T_PROD = 7'b0010000,
        T_ACC  = 7'b0100000,
        T_OUT  = 7'b1000000
    } top_state_t;

    top_state_t state_reg, state_next;
    logic [1:0] num_dims_reg;
    logic [LEN_W-1:0] len_reg [NUM_AXES];
    logic [1:0] nd_reg, nd_next, a_reg, a_next;
    logic [2:0] c_reg, c_next, cmax;
    logic [8:0] stride2_reg, stride2_next;
    logic [LEN_W-1:0] lenx_reg, lenx_next;
    logic [ADDR_W-1:0] flat_reg, flat_next;
    logic [FRAC_W-1:0] w_reg, w_next, g;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next, rnd;
    logic signed [VAL_W-1:0] mem_q;
    logic signed [VAL_W-1:0] mem [DATA_DEPTH];
    logic [2*FRAC_W-1:0] wprod;

    logic accept, q_start;
    logic [LEN_W-1:0] clen [NUM_AXES];
    logic signed [VAL_W-1:0] coords [NUM_AXES];
    logic [NUM_AXES-1:0] lane_done;
    lane_res_t lres [NUM_AXES];
    logic [PT_W-1:0] px, py, pz;
    logic [8:0] ymul;
    logic [12:0] zmul;
    logic [ADDR_W-1:0] flat_sum;
    logic [ACC_W-17:0] shifted;
    logic [LEN_W-1:0] lenx_c, leny_c;
    logic [9:0] stride_full;

    assign accept  = start && !busy;
    assign q_start = accept && (op == OP_QUERY);
    assign coords[0] = coord_x;
    assign coords[1] = coord_y;
    assign coords[2] = coord_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= 2'd1;
            len_reg[0]   <= LEN_W'(AXIS_LEN);
            len_reg[1]   <= LEN_W'(AXIS_LEN);
            len_reg[2]   <= LEN_W'(AXIS_LEN);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_DIMS: num_dims_reg <= cfg_wdata[1:0];
                CFG_LEN_X:    len_reg[0]   <= cfg_wdata;
                CFG_LEN_Y:    len_reg[1]   <= cfg_wdata;
                CFG_LEN_Z:    len_reg[2]   <= cfg_wdata;
                default:      num_dims_reg <= num_dims_reg;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_AXES; gi++)
        begin : g_lane
            assign clen[gi] = (len_reg[gi] == '0) ? LEN_W'(1) :
                              (len_reg[gi] > LEN_W'(AXIS_LEN)) ? LEN_W'(AXIS_LEN) : len_reg[gi];
            gmi_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .wr_en   (accept && op == OP_LOAD_AXIS && axis == 2'(gi)
                          && index[ADDR_W-1:PT_W] == '0),
                .wr_idx  (index[PT_W-1:0]),
                .wr_data (value),
                .start   (q_start),
                .key     (coords[gi]),
                .len     (clen[gi]),
                .done    (lane_done[gi]),
                .res     (lres[gi])
            );
        end
    endgenerate

    // Data store: one write port for loads, one registered read port for corners.
    always_ff @(posedge clk)
    begin
        if (accept && op == OP_LOAD_DATA)
        begin
            mem[index] <= value;
        end
        mem_q <= mem[flat_reg];
    end

    assign lenx_c      = clen[0];
    assign leny_c      = clen[1];
    assign stride_full = lenx_c * leny_c;

    always_comb
    begin
        case (nd_reg)
            2'd1:    cmax = 3'd1;
            2'd2:    cmax = 3'd3;
            default: cmax = 3'd7;
        endcase
    end

    assign px = c_reg[0] ? lres[0].hi_pt : lres[0].lo_pt;
    assign py = (nd_reg == 2'd1) ? '0 : (c_reg[1] ? lres[1].hi_pt : lres[1].lo_pt);
    assign pz = (nd_reg != 2'd3) ? '0 : (c_reg[2] ? lres[2].hi_pt : lres[2].lo_pt);
    assign ymul = py * lenx_reg;
    assign zmul = pz * stride2_reg;
    assign flat_sum = ADDR_W'(px) + ADDR_W'(ymul) + zmul[ADDR_W-1:0];

    assign g     = c_reg[a_reg] ? lres[a_reg].frac : ONE_Q16 - lres[a_reg].frac;
    assign wprod = w_reg * g;

    always_comb
    begin
        state_next   = state_reg;
        nd_next      = nd_reg;
        a_next       = a_reg;
        c_next       = c_reg;
        stride2_next = stride2_reg;
        lenx_next    = lenx_reg;
        flat_next    = flat_reg;
        w_next       = w_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (q_start)
                begin
                    nd_next      = (num_dims_reg == 2'd0) ? 2'd1 : num_dims_reg;
                    stride2_next = stride_full[8:0];
                    lenx_next    = lenx_c;
                    c_next       = '0;
                    acc_next     = '0;
                    state_next   = T_SRCH;
                end
            end
            T_SRCH:
            begin
                if (&lane_done)
                begin
                    state_next = T_ADDR;
                end
            end
            T_ADDR:
            begin
                flat_next  = flat_sum;
                w_next     = ONE_Q16;
                a_next     = '0;
                state_next = T_WGT;
            end
            T_WGT:
            begin
                w_next = wprod[FRAC_W+15:16];
                a_next = a_reg + 1'b1;
                if (a_reg == nd_reg - 1'b1)
                begin
                    state_next = T_PROD;
                end
            end
            T_PROD:
            begin
                prod_next  = $signed({1'b0, w_reg}) * mem_q;
                state_next = T_ACC;
            end
            T_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                c_next   = c_reg + 1'b1;
                state_next = (c_reg == cmax) ? T_OUT : T_ADDR;
            end
            T_OUT:
            begin
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nd_reg      <= nd_next;
        a_reg       <= a_next;
        c_reg       <= c_next;
        stride2_reg <= stride2_next;
        lenx_reg    <= lenx_next;
        flat_reg    <= flat_next;
        w_reg       <= w_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
    end

    // Round half up, floor by an arithmetic shift, then saturate to 32 bits.
    assign rnd     = acc_reg + ACC_W'(32768);
    assign shifted = rnd[ACC_W-1:16];

    always_comb
    begin
        if (shifted[ACC_W-17] && !(&shifted[ACC_W-17:VAL_W-1]))
        begin
            interp_value = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else if (!shifted[ACC_W-17] && (|shifted[ACC_W-17:VAL_W-1]))
        begin
            interp_value = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            interp_value = shifted[VAL_W-1:0];
        end
    end

    assign busy = (state_reg != T_IDLE);
    assign done = (state_reg == T_OUT);

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the grid multilinear interpolation core.
module testbench;
    import gmi_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 200;
    // Every grid shape used below stays within this many data words.
    localparam int DATA_USED   = 384;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [1:0]               cfg_index = CFG_NUM_DIMS;
    logic [LEN_W-1:0]         cfg_wdata = '0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               op = OP_LOAD_AXIS;
    logic [1:0]               axis = '0;
    logic [ADDR_W-1:0]        index = '0;
    logic signed [VAL_W-1:0]  value = '0;
    logic signed [VAL_W-1:0]  coord_x = '0;
    logic signed [VAL_W-1:0]  coord_y = '0;
    logic signed [VAL_W-1:0]  coord_z = '0;
    logic                     done;
    logic signed [VAL_W-1:0]  interp_value;

    localparam logic [1:0] OP_NONE = 2'd3;

    grid_multilinear_interp_core u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .start(start), .busy(busy), .op(op), .axis(axis),
        .index(index), .value(value), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .done(done), .interp_value(interp_value)
    );

    always #2 clk = ~clk;

    // Shadow copies of the block's registers and stores.
    logic [1:0]              dims_reg = 2'd1;
    logic [LEN_W-1:0]        len_reg [NUM_AXES];
    logic signed [VAL_W-1:0] axis_tab [NUM_AXES*AXIS_LEN];
    logic signed [VAL_W-1:0] grid_data [DATA_DEPTH];

    logic signed [VAL_W-1:0] expected_values [$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  no_idle = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_values.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", interp_value);
            end
            else
            begin
                if (interp_value !== expected_values[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("interp_value mismatch: expected %h actual %h",
                                 expected_values[0], interp_value);
                end
                void'(expected_values.pop_front());
            end
        end
    end

    function automatic void find_bracket(int a, int n, longint key, output int lo_pt,
                                         output int hi_pt, output longint frac);
        int lo;
        int hi;
        int mid;
        longint den;
        longint num;
        longint f;
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (key < longint'(axis_tab[a*AXIS_LEN+mid]))
                hi = mid;
            else
                lo = mid + 1;
        end
        lo_pt = (lo != 0) ? lo - 1 : 0;
        hi_pt = (lo == n) ? n - 1 : lo;
        frac = 0;
        if (lo_pt != hi_pt)
        begin
            den = longint'(axis_tab[a*AXIS_LEN+hi_pt]) - longint'(axis_tab[a*AXIS_LEN+lo_pt]);
            if (den > 0)
            begin
                num = key - longint'(axis_tab[a*AXIS_LEN+lo_pt]);
                if (num < 0)
                    num = 0;
                f = (num * 65536) / den;
                if (f > 65536)
                    f = 65536;
                frac = f;
            end
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] interpolate(longint keys [NUM_AXES]);
        int nd;
        int lens [NUM_AXES];
        int stride [NUM_AXES];
        int lo_pt [NUM_AXES];
        int hi_pt [NUM_AXES];
        longint frac [NUM_AXES];
        longint acc;
        longint w;
        longint res;
        int flat;
        nd = (dims_reg == 0) ? 1 : int'(dims_reg);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            lens[a] = int'(len_reg[a]);
            if (lens[a] < 1)
                lens[a] = 1;
            if (lens[a] > AXIS_LEN)
                lens[a] = AXIS_LEN;
        end
        stride[0] = 1;
        stride[1] = lens[0];
        stride[2] = lens[0] * lens[1];
        for (int a = 0; a < nd; a++)
            find_bracket(a, lens[a], keys[a], lo_pt[a], hi_pt[a], frac[a]);
        acc = 0;
        for (int c = 0; c < (1 << nd); c++)
        begin
            w = 65536;
            flat = 0;
            for (int a = 0; a < nd; a++)
            begin
                if ((c >> a) & 1)
                begin
                    w = (w * frac[a]) / 65536;
                    flat += hi_pt[a] * stride[a];
                end
                else
                begin
                    w = (w * (65536 - frac[a])) / 65536;
                    flat += lo_pt[a] * stride[a];
                end
            end
            if (flat < DATA_DEPTH)
                acc += w * longint'(grid_data[flat]);
        end
        res = (acc + 32768) >>> 16;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[VAL_W-1:0];
    endfunction

    // Drives one transaction and waits until the block takes it.
    task automatic send_item(logic [1:0] t_op, logic [1:0] t_axis, logic [ADDR_W-1:0] t_idx,
                             logic signed [VAL_W-1:0] t_val, logic signed [VAL_W-1:0] cx,
                             logic signed [VAL_W-1:0] cy, logic signed [VAL_W-1:0] cz);
        longint keys [NUM_AXES];
        @(negedge clk);
        start <= 1'b1;
        op <= t_op;
        axis <= t_axis;
        index <= t_idx;
        value <= t_val;
        coord_x <= cx;
        coord_y <= cy;
        coord_z <= cz;
        do
            @(posedge clk);
        while (busy);
        case (t_op)
            OP_LOAD_AXIS:
                if (t_axis < NUM_AXES && t_idx < AXIS_LEN)
                    axis_tab[t_axis*AXIS_LEN+t_idx] = t_val;
            OP_LOAD_DATA:
                grid_data[t_idx] = t_val;
            OP_QUERY:
            begin
                keys[0] = cx;
                keys[1] = cy;
                keys[2] = cz;
                expected_values.push_back(interpolate(keys));
            end
            default: ;
        endcase
    endtask

    task automatic maybe_idle();
        if (!no_idle && $urandom_range(3) == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(9)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [LEN_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_DIMS: dims_reg = data[1:0];
            CFG_LEN_X:    len_reg[0] = data;
            CFG_LEN_Y:    len_reg[1] = data;
            default:      len_reg[2] = data;
        endcase
    endtask

    task automatic set_config(logic [LEN_W-1:0] nd, logic [LEN_W-1:0] lx,
                              logic [LEN_W-1:0] ly, logic [LEN_W-1:0] lz);
        drain();
        write_reg(CFG_NUM_DIMS, nd);
        write_reg(CFG_LEN_X, lx);
        write_reg(CFG_LEN_Y, ly);
        write_reg(CFG_LEN_Z, lz);
    endtask

    // Table shapes: 0 sorted steps, 1 sorted with repeats, 2 unsorted, 3 full range.
    task automatic fill_axis(int a, int shape);
        longint pt;
        pt = -longint'($urandom_range(1 << 22));
        for (int i = 0; i < AXIS_LEN; i++)
        begin
            case (shape)
                0: pt += 1 + $urandom_range(1 << 20);
                1: pt += ($urandom_range(2) == 0) ? 0 : $urandom_range(1 << 18);
                2: pt = longint'($signed($urandom));
                default: pt = -64'sd2147483648 + longint'(i) * 286331153;
            endcase
            send_item(OP_LOAD_AXIS, a, i, pt[VAL_W-1:0], 0, 0, 0);
            maybe_idle();
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_coord(int a);
        int n;
        longint first;
        longint last;
        n = (len_reg[a] == 0) ? 1 : ((len_reg[a] > AXIS_LEN) ? AXIS_LEN : int'(len_reg[a]));
        first = axis_tab[a*AXIS_LEN];
        last = axis_tab[a*AXIS_LEN+n-1];
        case ($urandom_range(9))
            0: return $urandom;
            1: return axis_tab[a*AXIS_LEN+$urandom_range(n-1)];
            2: return first - 1 - $urandom_range(1000);
            default:
                if (last > first)
                    return first + (longint'($urandom) % (last - first + 1));
                else
                    return first;
        endcase
    endfunction

    task automatic send_query();
        send_item(OP_QUERY, $urandom, $urandom, $urandom,
                  pick_coord(0), pick_coord(1), pick_coord(2));
    endtask

    task automatic test_load_all();
        for (int a = 0; a < NUM_AXES; a++)
            fill_axis(a, 0);
        for (int i = 0; i < DATA_USED; i++)
        begin
            send_item(OP_LOAD_DATA, $urandom, i, $signed($urandom) >>> $urandom_range(24),
                      $urandom, $urandom, $urandom);
            maybe_idle();
        end
    endtask

    task automatic test_directed();
        // Queries with the reset setting, edges of the grid and far outside it.
        send_query();
        send_item(OP_QUERY, 0, 0, 0, 32'sh7FFFFFFF, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, 32'sh80000000, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, axis_tab[0], 0, 0);
        send_item(OP_QUERY, 0, 0, 0, axis_tab[AXIS_LEN-1], 0, 0);
        // Ignored transactions: bad axis, out-of-range point, unused op.
        send_item(OP_LOAD_AXIS, 2'd3, 0, 32'sh7FFFFFFF, 0, 0, 0);
        send_item(OP_LOAD_AXIS, 0, 12'hFFF, 32'sh80000000, 0, 0, 0);
        send_item(OP_NONE, 2'd3, 12'hFFF, 32'sh7FFFFFFF, '1, '1, '1);
        // Saturation: the largest, then the smallest values at every corner of a 3-D cell.
        set_config(3, 2, 2, 2);
        for (int i = 0; i < 8; i++)
            send_item(OP_LOAD_DATA, 0, (i & 1) + ((i >> 1) & 1) * 2 + (i >> 2) * 4,
                      32'sh7FFFFFFF, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, axis_tab[0], axis_tab[AXIS_LEN], axis_tab[2*AXIS_LEN]);
        send_query();
        for (int i = 0; i < 8; i++)
            send_item(OP_LOAD_DATA, 0, (i & 1) + ((i >> 1) & 1) * 2 + (i >> 2) * 4,
                      32'sh80000000, 0, 0, 0);
        send_query();
        // Zero register values and lengths past the table.
        set_config(0, 0, 31, 1);
        send_query();
        set_config(3, 16, 6, 4);
        send_query();
    endtask

    task automatic test_random(int rounds);
        for (int r = 0; r < rounds; r++)
        begin
            if ($urandom_range(3) == 0)
                set_config(3, 16, 1, 0);
            else
                set_config($urandom_range(3), $urandom_range(31) < 6 ? $urandom_range(31) :
                           $urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 4));
            if ($urandom_range(2) == 0)
                fill_axis($urandom_range(2), $urandom_range(3));
            repeat ($urandom_range(20))
            begin
                send_item(OP_LOAD_DATA, $urandom, $urandom_range(DATA_DEPTH - 1) >>
                          $urandom_range(6), $urandom, 0, 0, 0);
                maybe_idle();
            end
            repeat (40)
            begin
                if ($urandom_range(19) == 0)
                    send_item($urandom_range(1) ? OP_NONE : OP_LOAD_AXIS,
                              $urandom_range(1) ? 2'd3 : $urandom_range(2),
                              AXIS_LEN + $urandom_range(ADDR_W == 12 ? 4079 : 0),
                              $urandom, $urandom, $urandom, $urandom);
                else
                    send_query();
                maybe_idle();
            end
        end
    endtask

    initial
    begin
        for (int a = 0; a < NUM_AXES; a++)
            len_reg[a] = 5'd16;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_load_all();
        test_directed();
        test_random(8);
        no_idle = 1;
        test_random(3);
        drain();
        if (mismatches == 0 && expected_values.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
